>>> design/mmh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mmh_pkg
// Shared types, constants and helpers of the 64-bit murmur-style hash unit.
// ---------------------------------------------------------------------------
package mmh_pkg;

   localparam logic [63:0] MIX_C1     = 64'h87c3_7b91_1142_53d5;
   localparam logic [63:0] MIX_C2     = 64'h4cf5_ad43_2745_937f;
   localparam logic [63:0] ADD_ONE    = 64'h0000_0000_52dc_e729;
   localparam logic [63:0] ADD_TWO    = 64'h0000_0000_3849_5ab5;
   localparam logic [63:0] FMIX_M1    = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] FMIX_M2    = 64'hc4ce_b9fe_1a85_ec53;
   localparam logic [63:0] SEED_RESET = 64'h0000_00ba_beca_fe69;

   typedef enum logic [1:0] {
      MUL_C1,
      MUL_C2,
      MUL_F1,
      MUL_F2
   } mul_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_P,
      OP_MUL_S,
      OP_ROT,
      OP_MIX_A,
      OP_MIX_B,
      OP_MIX_C,
      OP_MIX_D,
      OP_TAIL,
      OP_FIN_A,
      OP_FIN_B,
      OP_XSH,
      OP_SAVE,
      OP_RESULT
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_C1P,
      ST_C1S,
      ST_ROT,
      ST_C2P,
      ST_C2S,
      ST_MA,
      ST_MB,
      ST_MC,
      ST_MD,
      ST_TAIL,
      ST_FA,
      ST_FB,
      ST_F1P,
      ST_F1S,
      ST_FXS,
      ST_F2P,
      ST_F2S,
      ST_SAVE,
      ST_RES
   } state_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic logic [63:0] mul_const(input mul_sel_type sel);
      logic [63:0] k;
      unique case (sel)
         MUL_C1:  k = MIX_C1;
         MUL_C2:  k = MIX_C2;
         MUL_F1:  k = FMIX_M1;
         MUL_F2:  k = FMIX_M2;
         default: k = MIX_C1;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

>>> design/murmur_style_64bit_hash_unit.sv
`default_nettype none
// a full block is accepted, then mixed in 9 steps: two 64-bit constant multiplies on one split
//   multiplier (a partial-product step and a sum step each), a rotate and 4 lane-update steps
// after the last full block or a tail, or straight after an empty tail, the finish runs
//   two fmix passes on the same multiplier
// synchronous active-high reset: seed 0xBABECAFE69, both lanes the seed, count zero
// ---------------------------------------------------------------------------
// murmur_style_64bit_hash_unit
// Streaming 64-bit murmur-style message hash with a programmable seed.
// ---------------------------------------------------------------------------
module murmur_style_64bit_hash_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_block_data,
   input  wire logic [3:0]  req_valid_bytes,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_hash_value,
   input  wire logic        csr_write_enable,
   input  wire logic [63:0] csr_write_data
);
   import mmh_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mmh_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_valid_bytes (req_valid_bytes),
      .req_last        (req_last),
      .cmd             (cmd),
      .status          (status)
   );

   mmh_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_block_data   (req_block_data),
      .req_valid_bytes  (req_valid_bytes),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule
`default_nettype wire

>>> design/mmh_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mmh_ctrl
// Sequencer: steps the datapath through block mixing and the final fmix.
// ---------------------------------------------------------------------------
module mmh_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [3:0]             req_valid_bytes,
   input  wire logic                   req_last,
   output mmh_pkg::dp_cmd_type         cmd,
   input  wire mmh_pkg::dp_status_type status
);
   import mmh_pkg::*;

   state_type state_ff, state_in;
   logic      tail_ff, tail_in;
   logic      fin_ff, fin_in;
   logic      second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tail_ff   <= 1'b0;
         fin_ff    <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tail_ff   <= tail_in;
         fin_ff    <= fin_in;
         second_ff <= second_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tail_in   = tail_ff;
      fin_in    = fin_ff;
      second_in = second_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.sel   = MUL_C1;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            second_in = 1'b0;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               priority if (req_valid_bytes[3]) begin
                  tail_in  = 1'b0;
                  fin_in   = req_last;
                  state_in = ST_C1P;
               end else if (req_valid_bytes != 4'd0) begin
                  tail_in  = 1'b1;
                  fin_in   = 1'b1;
                  state_in = ST_C1P;
               end else begin
                  // empty tail: nothing to mix, go straight to finish
                  state_in = ST_FA;
               end
            end
         end
         ST_C1P: begin
            cmd.op   = OP_MUL_P;
            cmd.sel  = MUL_C1;
            state_in = ST_C1S;
         end
         ST_C1S: begin
            cmd.op   = OP_MUL_S;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.op   = OP_ROT;
            state_in = ST_C2P;
         end
         ST_C2P: begin
            cmd.op   = OP_MUL_P;
            cmd.sel  = MUL_C2;
            state_in = ST_C2S;
         end
         ST_C2S: begin
            cmd.op   = OP_MUL_S;
            state_in = tail_ff ? ST_TAIL : ST_MA;
         end
         ST_MA: begin
            cmd.op   = OP_MIX_A;
            state_in = ST_MB;
         end
         ST_MB: begin
            cmd.op   = OP_MIX_B;
            state_in = ST_MC;
         end
         ST_MC: begin
            cmd.op   = OP_MIX_C;
            state_in = ST_MD;
         end
         ST_MD: begin
            cmd.op   = OP_MIX_D;
            state_in = fin_ff ? ST_FA : ST_IDLE;
         end
         ST_TAIL: begin
            cmd.op   = OP_TAIL;
            state_in = ST_FA;
         end
         ST_FA: begin
            cmd.op   = OP_FIN_A;
            state_in = ST_FB;
         end
         ST_FB: begin
            cmd.op   = OP_FIN_B;
            state_in = ST_F1P;
         end
         ST_F1P: begin
            cmd.op   = OP_MUL_P;
            cmd.sel  = MUL_F1;
            state_in = ST_F1S;
         end
         ST_F1S: begin
            cmd.op   = OP_MUL_S;
            state_in = ST_FXS;
         end
         ST_FXS: begin
            cmd.op   = OP_XSH;
            state_in = ST_F2P;
         end
         ST_F2P: begin
            cmd.op   = OP_MUL_P;
            cmd.sel  = MUL_F2;
            state_in = ST_F2S;
         end
         ST_F2S: begin
            cmd.op   = OP_MUL_S;
            state_in = second_ff ? ST_RES : ST_SAVE;
         end
         ST_SAVE: begin
            // lane one done, second pass runs fmix on lane two
            cmd.op    = OP_SAVE;
            second_in = 1'b1;
            state_in  = ST_F1P;
         end
         ST_RES: begin
            if (status.out_free) begin
               cmd.op   = OP_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/mmh_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mmh_datapath
// Lanes, byte count, seed, split 64-bit multiplier and the result register.
// ---------------------------------------------------------------------------
module mmh_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mmh_pkg::dp_cmd_type  cmd,
   output mmh_pkg::dp_status_type    status,
   input  wire logic [63:0]          req_block_data,
   input  wire logic [3:0]           req_valid_bytes,
   input  wire logic                 csr_write_enable,
   input  wire logic [63:0]          csr_write_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [63:0]               rsp_hash_value
);
   import mmh_pkg::*;

   logic [63:0] seed_ff;
   logic [63:0] lane_one_ff, lane_one_in;
   logic [63:0] lane_two_ff, lane_two_in;
   logic [63:0] byte_total_ff, byte_total_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] pp0_ff;
   logic [31:0] pp1_ff, pp2_ff;
   logic [63:0] hash_ff;
   logic        rsp_valid_ff;

   logic [63:0] mul_k;
   logic [63:0] pp0_in;
   logic [31:0] pp1_in, pp2_in;
   logic [63:0] mul_sum;
   logic [63:0] masked_data;
   logic [3:0]  byte_count;
   logic [63:0] l1x, l2x;

   function automatic logic [63:0] xsh33(input logic [63:0] x);
      return x ^ {33'd0, x[63:33]};
   endfunction

   // full 64-bit product mod 2^64 from three 32x32 partial products
   assign mul_k   = mul_const(cmd.sel);
   assign pp0_in  = acc_ff[31:0] * mul_k[31:0];
   assign pp1_in  = acc_ff[31:0] * mul_k[63:32];
   assign pp2_in  = acc_ff[63:32] * mul_k[31:0];
   assign mul_sum = pp0_ff + {pp1_ff + pp2_ff, 32'd0};

   // valid counts above eight act as a full block
   assign byte_count = req_valid_bytes[3] ? 4'd8 : req_valid_bytes;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked_data[i*8 +: 8] = (4'(i) < byte_count) ? req_block_data[i*8 +: 8] : 8'd0;
      end
   end

   assign l1x = lane_one_ff ^ acc_ff;
   assign l2x = lane_two_ff ^ acc_ff;

   always_ff @(posedge clock) begin
      pp0_ff <= pp0_in;
      pp1_ff <= pp1_in;
      pp2_ff <= pp2_in;
   end

   always_comb begin
      lane_one_in   = lane_one_ff;
      lane_two_in   = lane_two_ff;
      byte_total_in = byte_total_ff;
      acc_in        = acc_ff;
      unique case (cmd.op)
         OP_NONE, OP_MUL_P: begin
         end
         OP_LOAD: begin
            acc_in        = masked_data;
            byte_total_in = byte_total_ff + {60'd0, byte_count};
         end
         OP_MUL_S: acc_in = mul_sum;
         OP_ROT:   acc_in = {acc_ff[32:0], acc_ff[63:33]};
         OP_MIX_A: lane_one_in = {l1x[36:0], l1x[63:37]} + lane_two_ff;
         OP_MIX_B: lane_one_in = lane_one_ff + {lane_one_ff[61:0], 2'b00} + ADD_ONE;
         OP_MIX_C: lane_two_in = {l2x[22:0], l2x[63:23]} + lane_one_ff;
         OP_MIX_D: lane_two_in = lane_two_ff + {lane_two_ff[61:0], 2'b00} + ADD_TWO;
         OP_TAIL:  lane_one_in = l1x;
         OP_FIN_A: begin
            lane_one_in = (lane_one_ff ^ byte_total_ff) + (lane_two_ff ^ byte_total_ff);
            lane_two_in = lane_two_ff ^ byte_total_ff;
         end
         OP_FIN_B: begin
            lane_two_in = lane_two_ff + lane_one_ff;
            acc_in      = xsh33(lane_one_ff);
         end
         OP_XSH:   acc_in = xsh33(acc_ff);
         OP_SAVE: begin
            lane_one_in = xsh33(acc_ff);
            acc_in      = xsh33(lane_two_ff);
         end
         OP_RESULT: begin
            lane_one_in   = seed_ff;
            lane_two_in   = seed_ff;
            byte_total_in = 64'd0;
         end
         default: begin
         end
      endcase
      // a seed write before any byte of the message reloads the lanes
      if (csr_write_enable && (byte_total_ff == 64'd0)) begin
         lane_one_in = csr_write_data;
         lane_two_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= SEED_RESET;
         lane_one_ff   <= SEED_RESET;
         lane_two_ff   <= SEED_RESET;
         byte_total_ff <= 64'd0;
      end else begin
         if (csr_write_enable) begin
            seed_ff <= csr_write_data;
         end
         lane_one_ff   <= lane_one_in;
         lane_two_ff   <= lane_two_in;
         byte_total_ff <= byte_total_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.op == OP_RESULT) begin
         hash_ff <= lane_one_ff + xsh33(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_RESULT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hash_value  = hash_ff;

`ifndef ASSERT_OFF
   a_result_sets_out : assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |=> (rsp_valid_ff && (byte_total_ff == 64'd0)))
      else $error("result step did not raise rsp_valid and clear the count");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_RESULT) |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_seed_reload : assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && (byte_total_ff == 64'd0)) |=>
      ((lane_one_ff == seed_ff) && (lane_two_ff == seed_ff)))
      else $error("lanes did not reload the new seed");
`endif

endmodule
`default_nettype wire
